// ===== hdl/kbrq_pkg.sv =====
package kbrq_pkg;

   localparam int KEY_COUNT_DEF  = 256;
   localparam int RING_DEPTH_DEF = 16;

   localparam int CMD_W  = 3;
   localparam int KEY_W  = 8;
   localparam int CHAR_W = 8;
   localparam int TIME_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [TIME_W-1:0] FIRST_DELAY_RST = 32'd500;
   localparam logic [TIME_W-1:0] PERIOD_RST      = 32'd50;

   typedef enum logic [CMD_W-1:0] {
      CMD_PRESS   = 3'd0,
      CMD_RELEASE = 3'd1,
      CMD_TICK    = 3'd2,
      CMD_DEQUEUE = 3'd3,
      CMD_CLEAR   = 3'd4
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEXT_MODE   = 2'd0,
      CSR_FIRST_DELAY = 2'd1,
      CSR_PERIOD      = 2'd2
   } csr_index_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the request payload and start the ring read
      logic commit;    // apply the command and load the response register
   } ctrl_cmd_type;

endpackage

// ===== hdl/kbrq_ram.sv =====
module kbrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/kbrq_ctrl.sv =====
module kbrq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kbrq_pkg::ctrl_cmd_type ctrl
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      capture, commit;

   assign req_ready = (state_ff == ST_IDLE);
   assign capture   = req_valid && req_ready;
   // Commit only once the response register is free or being emptied
   assign commit    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign ctrl.capture = capture;
   assign ctrl.commit  = commit;

endmodule

// ===== hdl/kbrq_datapath.sv =====
module kbrq_datapath #(
   parameter int KEY_COUNT  = kbrq_pkg::KEY_COUNT_DEF,
   parameter int RING_DEPTH = kbrq_pkg::RING_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  kbrq_pkg::ctrl_cmd_type            ctrl,
   input  logic [kbrq_pkg::CMD_W-1:0]        req_cmd,
   input  logic [kbrq_pkg::KEY_W-1:0]        req_key_code,
   input  logic [kbrq_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [kbrq_pkg::TIME_W-1:0]       req_now,
   input  logic                              csr_we,
   input  logic [kbrq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kbrq_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                              rsp_pop_valid,
   output logic [kbrq_pkg::CHAR_W-1:0]       rsp_pop_char,
   output logic                              rsp_queue_empty,
   output logic                              rsp_key_is_down,
   output logic                              rsp_overflow
);

   localparam int KEY_IDX_W = $clog2(KEY_COUNT);
   localparam int RING_W    = $clog2(RING_DEPTH);
   localparam logic [kbrq_pkg::KEY_W:0] KEY_LIMIT  = (kbrq_pkg::KEY_W+1)'(KEY_COUNT);
   localparam logic [RING_W-1:0]        RING_LAST  = RING_W'(RING_DEPTH - 1);

   // Latched request
   logic [kbrq_pkg::CMD_W-1:0]  cmd_ff;
   logic [kbrq_pkg::KEY_W-1:0]  key_ff;
   logic [kbrq_pkg::CHAR_W-1:0] char_ff;
   logic [kbrq_pkg::TIME_W-1:0] now_ff;

   // Configuration
   logic                        text_mode_ff;
   logic [kbrq_pkg::TIME_W-1:0] first_delay_ff;
   logic [kbrq_pkg::TIME_W-1:0] period_ff;

   // Keyboard and repeat state
   logic [KEY_COUNT-1:0]        down_ff, down_in;
   logic [RING_W-1:0]           head_ff, head_in, tail_ff, tail_in;
   logic [kbrq_pkg::KEY_W-1:0]  rep_key_ff, rep_key_in;
   logic [kbrq_pkg::CHAR_W-1:0] rep_char_ff, rep_char_in;
   logic                        armed_ff, armed_in;
   logic                        live_ff, live_in;   // armed and repeat key held down
   logic [kbrq_pkg::TIME_W-1:0] last_tick_ff, last_tick_in;
   logic [kbrq_pkg::TIME_W-1:0] deadline_ff, deadline_in;

   // Response register
   logic                        pop_valid_ff, pop_valid_in;
   logic [kbrq_pkg::CHAR_W-1:0] pop_char_ff, pop_char_in;
   logic                        empty_ff, empty_in;
   logic                        down_out_ff, down_out_in;
   logic                        ovf_ff, ovf_in;

   logic                        key_ok;
   logic [KEY_IDX_W-1:0]        key_idx;
   logic [RING_W-1:0]           tail_next, head_next;
   logic                        ring_full, ring_empty;
   logic                        push, push_ok;
   logic [kbrq_pkg::CHAR_W-1:0] push_char;
   logic [kbrq_pkg::CHAR_W-1:0] ram_rd_data;

   assign key_ok     = {1'b0, key_ff} < KEY_LIMIT;
   assign key_idx    = key_ff[KEY_IDX_W-1:0];
   assign tail_next  = (tail_ff == RING_LAST) ? '0 : tail_ff + 1'b1;
   assign head_next  = (head_ff == RING_LAST) ? '0 : head_ff + 1'b1;
   assign ring_full  = (tail_next == head_ff);
   assign ring_empty = (head_ff == tail_ff);

   always_comb begin
      down_in      = down_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      rep_key_in   = rep_key_ff;
      rep_char_in  = rep_char_ff;
      armed_in     = armed_ff;
      live_in      = live_ff;
      last_tick_in = last_tick_ff;
      deadline_in  = deadline_ff;
      push         = 1'b0;
      push_char    = char_ff;
      pop_valid_in = 1'b0;
      unique case (cmd_ff)
         kbrq_pkg::CMD_PRESS: begin
            if (text_mode_ff) begin
               push        = 1'b1;
               rep_key_in  = key_ff;
               rep_char_in = char_ff;
               armed_in    = 1'b1;
               live_in     = key_ok;
               deadline_in = last_tick_ff + first_delay_ff;
            end else if (armed_ff && key_ok && (key_ff == rep_key_ff)) begin
               live_in = 1'b1;
            end
            if (key_ok) begin
               down_in[key_idx] = 1'b1;
            end
         end
         kbrq_pkg::CMD_RELEASE: begin
            if (key_ok) begin
               down_in[key_idx] = 1'b0;
            end
            armed_in = 1'b0;
            live_in  = 1'b0;
         end
         kbrq_pkg::CMD_TICK: begin
            if (text_mode_ff) begin
               last_tick_in = now_ff;
               if (live_ff && (now_ff >= deadline_ff)) begin
                  push        = 1'b1;
                  push_char   = rep_char_ff;
                  deadline_in = now_ff + period_ff;
               end
            end
         end
         kbrq_pkg::CMD_DEQUEUE: begin
            if (text_mode_ff && !ring_empty) begin
               pop_valid_in = 1'b1;
               head_in      = head_next;
            end
         end
         kbrq_pkg::CMD_CLEAR: begin
            down_in = '0;
            head_in = '0;
            tail_in = '0;
            live_in = 1'b0;
         end
         default: begin
         end
      endcase
      // Drop the character when the ring is full
      push_ok = push && !ring_full;
      if (push_ok) begin
         tail_in = tail_next;
      end
      ovf_in      = push && ring_full;
      pop_char_in = pop_valid_in ? ram_rd_data : '0;
      empty_in    = !text_mode_ff || (head_in == tail_in);
      down_out_in = key_ok && down_in[key_idx];
   end

   kbrq_ram #(
      .WIDTH (kbrq_pkg::CHAR_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ctrl.commit && push_ok),
      .wr_addr (tail_ff),
      .wr_data (push_char),
      .rd_en   (ctrl.capture),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // Payload latches
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff  <= req_cmd;
         key_ff  <= req_key_code;
         char_ff <= req_char_code;
         now_ff  <= req_now;
      end
      if (ctrl.commit) begin
         pop_valid_ff <= pop_valid_in;
         pop_char_ff  <= pop_char_in;
         empty_ff     <= empty_in;
         down_out_ff  <= down_out_in;
         ovf_ff       <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_mode_ff   <= 1'b0;
         first_delay_ff <= kbrq_pkg::FIRST_DELAY_RST;
         period_ff      <= kbrq_pkg::PERIOD_RST;
         down_ff        <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         rep_key_ff     <= '0;
         rep_char_ff    <= '0;
         armed_ff       <= 1'b0;
         live_ff        <= 1'b0;
         last_tick_ff   <= '0;
         deadline_ff    <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               kbrq_pkg::CSR_TEXT_MODE:   text_mode_ff   <= csr_wdata[0];
               kbrq_pkg::CSR_FIRST_DELAY: first_delay_ff <= csr_wdata;
               kbrq_pkg::CSR_PERIOD:      period_ff      <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (ctrl.commit) begin
            down_ff      <= down_in;
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            rep_key_ff   <= rep_key_in;
            rep_char_ff  <= rep_char_in;
            armed_ff     <= armed_in;
            live_ff      <= live_in;
            last_tick_ff <= last_tick_in;
            deadline_ff  <= deadline_in;
         end
      end
   end

   assign rsp_pop_valid   = pop_valid_ff;
   assign rsp_pop_char    = pop_char_ff;
   assign rsp_queue_empty = empty_ff;
   assign rsp_key_is_down = down_out_ff;
   assign rsp_overflow    = ovf_ff;

endmodule

// ===== hdl/keyboard_repeat_queue.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  cmd, key_code, char_code, now
// rsp_      out        rsp_valid / rsp_ready  pop_valid, pop_char, queue_empty,
//                                             key_is_down, overflow
// csr_      in         csr_we (no wait)       csr_index, csr_wdata
//
// Each command is first latched, which starts the ring read, and then applied, which
// loads the response register; no new transfer is taken until the last is committed.
// The commit waits while a response is still held: with rsp_ stalled, one response
// is held, one more command is latched, and intake then stops.
// Reset is synchronous and clears the key bitmap, ring pointers and repeat state
// at once; there is no clearing pass. The ring contents are not reset.
module keyboard_repeat_queue #(
   parameter int KEY_COUNT  = kbrq_pkg::KEY_COUNT_DEF,
   parameter int RING_DEPTH = kbrq_pkg::RING_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [kbrq_pkg::CMD_W-1:0]      req_cmd,
   input  logic [kbrq_pkg::KEY_W-1:0]      req_key_code,
   input  logic [kbrq_pkg::CHAR_W-1:0]     req_char_code,
   input  logic [kbrq_pkg::TIME_W-1:0]     req_now,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_pop_valid,
   output logic [kbrq_pkg::CHAR_W-1:0]     rsp_pop_char,
   output logic                            rsp_queue_empty,
   output logic                            rsp_key_is_down,
   output logic                            rsp_overflow,
   // configuration writes
   input  logic                            csr_we,
   input  logic [kbrq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kbrq_pkg::CSR_DATA_W-1:0] csr_wdata
);

   kbrq_pkg::ctrl_cmd_type ctrl;

   // Sequence each transfer: latch, then commit into state and response
   kbrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   // Hold the bitmap, the ring, the repeat timer and the response register
   kbrq_datapath #(
      .KEY_COUNT  (KEY_COUNT),
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_cmd         (req_cmd),
      .req_key_code    (req_key_code),
      .req_char_code   (req_char_code),
      .req_now         (req_now),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_pop_valid   (rsp_pop_valid),
      .rsp_pop_char    (rsp_pop_char),
      .rsp_queue_empty (rsp_queue_empty),
      .rsp_key_is_down (rsp_key_is_down),
      .rsp_overflow    (rsp_overflow)
   );

   // A dropped character means the ring was full, so it cannot be empty now
   a_ovf_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> !rsp_queue_empty)
      else $error("overflow reported with an empty queue");

   // A response never both pops and drops a character
   a_pop_xor_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_pop_valid && rsp_overflow))
      else $error("pop and overflow in the same response");

   // An empty pop carries a zero character
   a_pop_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pop_valid |-> rsp_pop_char == '0)
      else $error("non-zero character without pop");

   // One command at a time: intake stays closed from the latch until the commit
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken during commit");

endmodule
